### rtl/mrlw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrlw_pkg: shared types and constants of the Modbus request link watch
// Command codes, register indexes, the window cell record, the status and
// event records between the top level and the link monitor, and the
// byte-wide CRC-16 (Modbus) update.
// ----------------------------------------------------------------------------
package mrlw_pkg;

  // Window and frame sizing
  localparam int WINDOW_BYTES       = 8;
  localparam int CRC_CELLS          = 6;   // cells that fold the new byte into a CRC
  localparam int FRAME_BUFFER_BYTES = 128;
  localparam int COUNT_W            = 8;
  localparam int CFG_INDEX_W        = 3;
  localparam int CFG_DATA_W         = 16;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Register reset values
  localparam logic [7:0]  DEV_ADDR_RST   = 8'h01;
  localparam logic [7:0]  FUNC_CODE_RST  = 8'h03;
  localparam logic [15:0] START_WORD_RST = 16'h1000;
  localparam logic [15:0] COUNT_WORD_RST = 16'h0700;
  localparam logic [7:0]  ERR_LIMIT_RST  = 8'd10;
  localparam logic [7:0]  TIMEOUT_RST    = 8'd100;

  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_EOF  = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DEV_ADDR   = 3'd0,
    REG_FUNC_CODE  = 3'd1,
    REG_START_WORD = 3'd2,
    REG_COUNT_WORD = 3'd3,
    REG_ERR_LIMIT  = 3'd4,
    REG_TIMEOUT    = 3'd5
  } reg_index_t;

  // One window cell: the byte it holds and the CRC of the bytes behind it
  typedef struct packed {
    logic [7:0]  octet;
    logic [15:0] crc;
  } cell_t;

  // Frame status from the link monitor
  typedef struct packed {
    logic               byte_room;    // frame buffer not yet full
    logic               window_full;  // next byte brings the frame to eight bytes or more
    logic [COUNT_W-1:0] byte_count;
  } frame_status_t;

  // Accepted word as seen by the link monitor
  typedef struct packed {
    logic accept;
    cmd_t cmd;
    logic window_hit;
  } frame_event_t;

  // Fold one byte into a CRC-16 (Modbus, reflected)
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### rtl/mrlw_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrlw_in_if: input word channel
// Valid/ready channel carrying a command and a received byte.
// ----------------------------------------------------------------------------
interface mrlw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

### rtl/mrlw_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrlw_out_if: result word channel
// Valid/ready channel carrying the match flag and the link flag.
// ----------------------------------------------------------------------------
interface mrlw_out_if;
  logic valid;
  logic ready;
  logic frame_matched;
  logic link_up;

  modport source (output valid, output frame_matched, output link_up, input ready);
  modport sink   (input valid, input frame_matched, input link_up, output ready);
endinterface

### rtl/mrlw_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrlw_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface mrlw_cfg_if;
  import mrlw_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/mrlw_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrlw_cell: one cell of the byte window chain
// Takes the byte of its left neighbour on each shift and either folds the
// incoming byte into the neighbour's CRC or passes that CRC on unchanged.
// ----------------------------------------------------------------------------
module mrlw_cell
  import mrlw_pkg::*;
(
  input  logic       clk,
  input  logic       shift_en,
  input  logic       calc_en,
  input  logic [7:0] data_byte,
  input  cell_t      left_in,
  output cell_t      cell_r
);

  cell_t cell_nxt;

  // Fold the new byte, or hand the neighbour's CRC along as a delay
  always_comb begin
    cell_nxt.octet = left_in.octet;
    cell_nxt.crc   = calc_en ? crc16_byte(left_in.crc, data_byte) : left_in.crc;
  end

  // Shift on every accepted byte of a frame while the frame buffer has room
  always_ff @(posedge clk) begin
    if (shift_en) begin
      cell_r <= cell_nxt;
    end
  end

endmodule

### rtl/mrlw_link_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrlw_link_monitor: frame and link supervision
// Counts frame bytes, latches a window hit, counts failed frames and idle
// ticks and keeps the link flag. Gives the result of each accepted word.
// ----------------------------------------------------------------------------
module mrlw_link_monitor
  import mrlw_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  frame_event_t  evt,
  input  logic [7:0]    error_limit,
  input  logic [7:0]    timeout_ticks,
  output frame_status_t status,
  output logic          matched_nxt,
  output logic          link_nxt
);

  localparam logic [COUNT_W-1:0] BUF_LIMIT  = COUNT_W'(FRAME_BUFFER_BYTES);
  localparam logic [COUNT_W-1:0] FULL_MARK  = COUNT_W'(WINDOW_BYTES - 1);

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               seen_r, seen_nxt;
  logic [7:0]         failed_r, failed_nxt;
  logic [7:0]         idle_r, idle_nxt;
  logic               link_r;

  assign status.byte_room   = (count_r < BUF_LIMIT);
  assign status.window_full = (count_r >= FULL_MARK);
  assign status.byte_count  = count_r;

  // Work out the next state for the accepted word
  always_comb begin
    count_nxt   = count_r;
    seen_nxt    = seen_r;
    failed_nxt  = failed_r;
    idle_nxt    = idle_r;
    link_nxt    = link_r;
    matched_nxt = 1'b0;
    case (evt.cmd)
      CMD_BYTE: begin
        if (status.byte_room) begin
          count_nxt = count_r + 1'b1;
          if (status.window_full && evt.window_hit) begin
            seen_nxt = 1'b1;
          end
        end
      end
      CMD_EOF: begin
        if (seen_r) begin
          failed_nxt  = '0;
          link_nxt    = 1'b1;
          matched_nxt = 1'b1;
        end else begin
          if (failed_r != 8'hFF) begin
            failed_nxt = failed_r + 1'b1;
          end
          if (failed_nxt > error_limit) begin
            link_nxt = 1'b0;
          end
        end
        count_nxt = '0;
        seen_nxt  = 1'b0;
        idle_nxt  = '0;
      end
      CMD_TICK: begin
        if (idle_r != 8'hFF) begin
          idle_nxt = idle_r + 1'b1;
        end
        if (idle_nxt > timeout_ticks) begin
          link_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Commit on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      seen_r   <= 1'b0;
      failed_r <= '0;
      idle_r   <= '0;
      link_r   <= 1'b0;
    end else if (evt.accept) begin
      count_r  <= count_nxt;
      seen_r   <= seen_nxt;
      failed_r <= failed_nxt;
      idle_r   <= idle_nxt;
      link_r   <= link_nxt;
    end
  end

endmodule

### rtl/modbus_request_match_link_watch_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_request_match_link_watch_core: Modbus RTU request watch, top level
// Byte window chain, request compare, link monitor and result register.
// ----------------------------------------------------------------------------
// Each input word (received byte, end of frame or time tick) gives exactly one
// registered result word, and the block takes one word per clock cycle: the
// result register is reloaded in the same cycle it is drained, so input ready
// only falls while a result waits unread. The CRC-16 of every six-byte span is
// built up across a chain of eight window cells, the first six folding one
// byte per shift, so the request check at each byte compares the registered
// cells and the incoming byte with the configured address, function code,
// start and count words and the CRC. Configuration writes are always accepted
// and take effect on the next word; write them only while the block is idle.
// ----------------------------------------------------------------------------
module modbus_request_match_link_watch_core
  import mrlw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  mrlw_in_if.sink     in_chan,
  mrlw_out_if.source  out_chan,
  mrlw_cfg_if.sink    cfg_chan
);

  // Configuration registers
  logic [7:0]  dev_addr_r;
  logic [7:0]  func_code_r;
  logic [15:0] start_word_r;
  logic [15:0] count_word_r;
  logic [7:0]  err_limit_r;
  logic [7:0]  timeout_r;

  assign cfg_chan.ready = 1'b1;

  // Write at most one register per accepted config word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r   <= DEV_ADDR_RST;
      func_code_r  <= FUNC_CODE_RST;
      start_word_r <= START_WORD_RST;
      count_word_r <= COUNT_WORD_RST;
      err_limit_r  <= ERR_LIMIT_RST;
      timeout_r    <= TIMEOUT_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        REG_DEV_ADDR:   dev_addr_r   <= cfg_chan.data[7:0];
        REG_FUNC_CODE:  func_code_r  <= cfg_chan.data[7:0];
        REG_START_WORD: start_word_r <= cfg_chan.data;
        REG_COUNT_WORD: count_word_r <= cfg_chan.data;
        REG_ERR_LIMIT:  err_limit_r  <= cfg_chan.data[7:0];
        REG_TIMEOUT:    timeout_r    <= cfg_chan.data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Input handshake
  logic in_accept;
  logic out_valid_r;
  logic matched_r, link_r;
  logic matched_nxt, link_nxt;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_accept     = in_chan.valid && in_chan.ready;

  frame_status_t status;
  frame_event_t  evt;
  logic          shift_en;

  assign shift_en = in_accept && (cmd_t'(in_chan.command) == CMD_BYTE) && status.byte_room;

  // Window chain: cell 0 holds the newest byte
  cell_t cells [WINDOW_BYTES];
  cell_t lefts [WINDOW_BYTES];

  assign lefts[0] = '{octet: in_chan.data_byte, crc: CRC_INIT};

  for (genvar k = 0; k < WINDOW_BYTES; k++) begin : g_cell
    if (k > 0) begin : g_link
      assign lefts[k] = cells[k-1];
    end
    mrlw_cell u_cell (
      .clk       (clk),
      .shift_en  (shift_en),
      .calc_en   (1'(k < CRC_CELLS)),
      .data_byte (in_chan.data_byte),
      .left_in   (lefts[k]),
      .cell_r    (cells[k])
    );
  end

  // Compare the window as it will stand after this byte; cell 6 carries the
  // CRC of the six bytes that then open it
  logic window_hit;

  always_comb begin
    window_hit = (cells[6].octet == dev_addr_r)
              && (cells[5].octet == func_code_r)
              && ({cells[3].octet, cells[4].octet} == start_word_r)
              && ({cells[1].octet, cells[2].octet} == count_word_r)
              && ({in_chan.data_byte, cells[0].octet} == cells[6].crc);
  end

  assign evt.accept     = in_accept;
  assign evt.cmd        = cmd_t'(in_chan.command);
  assign evt.window_hit = window_hit;

  mrlw_link_monitor u_monitor (
    .clk           (clk),
    .rst_n         (rst_n),
    .evt           (evt),
    .error_limit   (err_limit_r),
    .timeout_ticks (timeout_r),
    .status        (status),
    .matched_nxt   (matched_nxt),
    .link_nxt      (link_nxt)
  );

  // Result register: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      matched_r <= matched_nxt;
      link_r    <= link_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.frame_matched = matched_r;
  assign out_chan.link_up       = link_r;

  // Checks
  a_match_means_link: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && matched_r |-> link_r)
    else $error("match reported without link up");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    status.byte_count <= COUNT_W'(FRAME_BUFFER_BYTES))
    else $error("frame byte count beyond buffer");

  a_eof_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (cmd_t'(in_chan.command) == CMD_EOF) |=> status.byte_count == '0)
    else $error("end of frame did not clear byte count");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |=> out_valid_r && $stable(matched_r) && $stable(link_r))
    else $error("result changed while stalled");

  a_short_frame_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (cmd_t'(in_chan.command) == CMD_EOF)
      && (status.byte_count < COUNT_W'(WINDOW_BYTES)) |=> !matched_r)
    else $error("short frame reported as matched");

endmodule
